@@ rtl/cdo_pkg.sv @@
// Package for the calendar date offset unit: widths, calendar constants,
// datapath commands, controller/datapath status and small lookup functions.
// No dependencies.
package cdo_pkg;

  localparam int YEAR_SPAN = 256;
  localparam int BASE_YEAR = 1900;

  localparam int YW    = 12;
  localparam int MW    = 4;
  localparam int DW    = 5;
  localparam int OW    = 16;
  localparam int WDW   = 3;
  localparam int DNOW  = 17;
  localparam int DNW   = 23;
  localparam int QW    = 6;
  localparam int YOW   = $clog2(YEAR_SPAN + 1);
  localparam int MULW  = YW + 1;
  localparam int PRODW = 2 * MULW;

  // x / 100 as (x * DIV100_MUL) >> DIV100_SH, exact for x below 4500
  localparam int DIV100_MUL = 5243;
  localparam int DIV100_SH  = 19;
  localparam int SHIFT_ADD  = 399;

  localparam int RefShift  = BASE_YEAR + SHIFT_ADD;
  localparam int REF_LEAPS = RefShift / 4 - RefShift / 100 + RefShift / 400;
  localparam int EndShift  = BASE_YEAR + YEAR_SPAN + SHIFT_ADD;
  localparam int LAST_DAY  = 365 * YEAR_SPAN
                             + (EndShift / 4 - EndShift / 100 + EndShift / 400)
                             - REF_LEAPS;

  localparam logic signed [DNW-1:0] BASE_YEAR_S = DNW'(BASE_YEAR);
  localparam logic signed [DNW-1:0] DAYS_YEAR_S = DNW'(365);
  localparam logic signed [DNW-1:0] REF_LEAPS_S = DNW'(REF_LEAPS);
  localparam logic signed [DNW-1:0] LAST_DAY_S  = DNW'(LAST_DAY);
  localparam logic signed [DNW-1:0] ONE_S       = DNW'(1);

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_QYEAR,
    DP_QSHIFT,
    DP_BASE,
    DP_SUM,
    DP_RANGE,
    DP_YEAR,
    DP_MONTH,
    DP_OUT
  } dp_op_e;

  typedef struct packed {
    logic date_ok;
    logic in_range;
    logic year_more;
    logic month_more;
  } dp_status_t;

  function automatic logic [DW-1:0] month_len(input logic [MW-1:0] m);
    logic [DW-1:0] n;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
      4'd2:                                       n = 5'd28;
      default:                                    n = 5'd0;
    endcase
    return n;
  endfunction

  // days before the first of month m in a common year
  function automatic logic [8:0] days_before_month(input logic [MW-1:0] m);
    logic [8:0] n;
    case (m)
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

  function automatic logic [WDW-1:0] mod7_small(input logic [5:0] v);
    logic [5:0] r;
    r = v;
    for (int i = 0; i < 5; i++) begin
      if (r >= 6'd7) begin
        r = r - 6'd7;
      end
    end
    return r[WDW-1:0];
  endfunction

endpackage

@@ rtl/calendar_date_offset_unit_top.sv @@
// Calendar date offset unit, top level: controller plus datapath.
// Depends on cdo_pkg, cdo_ctrl and cdo_datapath.
//
// Input channel: in_valid_i / in_stall_o carry one date (year, month, day)
// and a signed day offset; a transaction completes when valid is high and
// stall is low. Output channel: out_valid_o / out_stall_i carry one result
// per input: date_valid_o, out_of_range_o, the moved date, its weekday
// (0 = Monday) and its day number (1900-01-01 is day 1).
// An illegal date is emitted after the date check and an out of span result
// after the range check; otherwise the year walk (one year per cycle) and then
// the month walk run first, so the wait grows with the whole years past 1900
// and the whole months in the final year.
// One item is in flight at a time; in_stall_o is high while it is worked
// on. A finished result sits in the output register while the receiver
// stalls, and the next input transaction is already taken meanwhile; the
// following result waits until the register is free.
// Reset (rst_ni low, asynchronous) returns to idle and drops out_valid_o.
module calendar_date_offset_unit_top import cdo_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [YW-1:0]         in_year_i,
  input  logic [MW-1:0]         in_month_i,
  input  logic [DW-1:0]         in_day_i,
  input  logic signed [OW-1:0]  offset_days_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  date_valid_o,
  output logic                  out_of_range_o,
  output logic [YW-1:0]         out_year_o,
  output logic [MW-1:0]         out_month_o,
  output logic [DW-1:0]         out_day_o,
  output logic [WDW-1:0]        weekday_o,
  output logic [DNOW-1:0]       day_number_o
);

  dp_op_e     op;
  dp_status_t status;

  cdo_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .op_o        (op)
  );

  cdo_datapath u_datapath (
    .clk_i          (clk_i),
    .op_i           (op),
    .status_o       (status),
    .in_year_i      (in_year_i),
    .in_month_i     (in_month_i),
    .in_day_i       (in_day_i),
    .offset_days_i  (offset_days_i),
    .date_valid_o   (date_valid_o),
    .out_of_range_o (out_of_range_o),
    .out_year_o     (out_year_o),
    .out_month_o    (out_month_o),
    .out_day_o      (out_day_o),
    .weekday_o      (weekday_o),
    .day_number_o   (day_number_o)
  );

endmodule

@@ rtl/cdo_ctrl.sv @@
// Controller of the calendar date offset unit: sequences the datapath
// and runs both handshakes. Depends on cdo_pkg.
module cdo_ctrl import cdo_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  dp_status_t status_i,
  output dp_op_e     op_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_QYEAR,
    S_QSHIFT,
    S_BASE,
    S_SUM,
    S_RANGE,
    S_YEAR,
    S_MONTH,
    S_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    op_o        = DP_NOP;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_o    = DP_LOAD;
          state_d = S_QYEAR;
        end
      end
      S_QYEAR: begin
        op_o    = DP_QYEAR;
        state_d = S_QSHIFT;
      end
      S_QSHIFT: begin
        op_o    = DP_QSHIFT;
        state_d = S_BASE;
      end
      S_BASE: begin
        op_o    = DP_BASE;
        state_d = S_SUM;
      end
      S_SUM: begin
        op_o    = DP_SUM;
        state_d = status_i.date_ok ? S_RANGE : S_EMIT;
      end
      S_RANGE: begin
        op_o    = DP_RANGE;
        state_d = S_YEAR;
      end
      S_YEAR: begin
        if (!status_i.in_range) begin
          state_d = S_EMIT;
        end else if (status_i.year_more) begin
          op_o = DP_YEAR;
        end else begin
          state_d = S_MONTH;
        end
      end
      S_MONTH: begin
        if (status_i.month_more) begin
          op_o = DP_MONTH;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          op_o        = DP_OUT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_QYEAR))
    else $error("accepted transaction did not start the sequence");

  a_result_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_EMIT))
    else $error("result raised outside emit");

  a_year_walk_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_YEAR) |-> status_i.date_ok)
    else $error("year walk on an invalid date");

  a_month_walk_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MONTH) |-> (status_i.date_ok && status_i.in_range))
    else $error("month walk on an invalid or out of range date");

endmodule

@@ rtl/cdo_datapath.sv @@
// Datapath of the calendar date offset unit: date check, day number,
// year and month walk, weekday and result registers. Depends on cdo_pkg.
module cdo_datapath import cdo_pkg::*; (
  input  logic                  clk_i,
  input  dp_op_e                op_i,
  output dp_status_t            status_o,
  input  logic [YW-1:0]         in_year_i,
  input  logic [MW-1:0]         in_month_i,
  input  logic [DW-1:0]         in_day_i,
  input  logic signed [OW-1:0]  offset_days_i,
  output logic                  date_valid_o,
  output logic                  out_of_range_o,
  output logic [YW-1:0]         out_year_o,
  output logic [MW-1:0]         out_month_o,
  output logic [DW-1:0]         out_day_o,
  output logic [WDW-1:0]        weekday_o,
  output logic [DNOW-1:0]       day_number_o
);

  logic [YW-1:0]          year_q;
  logic [MW-1:0]          month_q;
  logic [DW-1:0]          day_q;
  logic signed [OW-1:0]   offset_q;
  logic [QW-1:0]          qy_q, qs_q;
  logic                   leap_q, date_ok_q, range_ok_q;
  logic signed [DNW-1:0]  dby_q, dn_q;
  logic [DNOW-1:0]        dnum_q;
  logic [YOW-1:0]         yoff_q;
  logic [1:0]             c4_q;
  logic [6:0]             c100_q;
  logic [8:0]             c400_q;
  logic [MW-1:0]          mon_q;
  logic [WDW-1:0]         wd_q;

  logic [MULW-1:0]        shift_arg, mul_arg;
  logic [PRODW-1:0]       mul_prod;
  logic [QW-1:0]          quot;
  logic [MULW-1:0]        hund;
  logic                   leap_in;
  logic [DW-1:0]          in_mlen;
  logic                   date_ok_d;
  logic signed [DNW-1:0]  yrel, dby_d, dn_sum;
  logic                   cur_leap;
  logic signed [DNW-1:0]  ylen;
  logic [DW-1:0]          dim;
  logic [3:0]             wd_y_sum, wd_m_sum;
  logic [WDW-1:0]         wd_y_next, wd_m_next;
  logic [YOW+YW-1:0]      year_full;
  logic [WDW-1:0]         wd_final;

  assign shift_arg = MULW'(year_q) + MULW'(SHIFT_ADD);
  assign mul_arg   = (op_i == DP_QSHIFT) ? shift_arg : MULW'(year_q);
  assign mul_prod  = PRODW'(mul_arg) * PRODW'(DIV100_MUL);
  assign quot      = mul_prod[DIV100_SH +: QW];

  assign hund    = MULW'(qy_q) * MULW'(100);
  assign leap_in = (year_q[1:0] == 2'b00) &&
                   ((MULW'(year_q) != hund) || (qy_q[1:0] == 2'b00));

  assign in_mlen   = month_len(month_q) + DW'(leap_q && (month_q == 4'd2));
  assign date_ok_d = (month_q >= 4'd1) && (month_q <= 4'd12) &&
                     (day_q != '0) && (day_q <= in_mlen);

  assign yrel  = signed'(DNW'(year_q)) - BASE_YEAR_S;
  assign dby_d = yrel * DAYS_YEAR_S
                 + signed'(DNW'(shift_arg >> 2))
                 - signed'(DNW'(qs_q))
                 + signed'(DNW'(qs_q >> 2))
                 - REF_LEAPS_S;

  assign dn_sum = dby_q
                  + signed'(DNW'(days_before_month(month_q)))
                  + signed'(DNW'(leap_q && (month_q > 4'd2)))
                  + signed'(DNW'(day_q))
                  - signed'({{(DNW-OW){offset_q[OW-1]}}, offset_q});

  assign cur_leap = (c4_q == 2'd0) && ((c100_q != 7'd0) || (c400_q == 9'd0));
  assign ylen     = DAYS_YEAR_S + signed'(DNW'(cur_leap));
  assign dim      = month_len(mon_q) + DW'(cur_leap && (mon_q == 4'd2));

  assign wd_y_sum  = 4'(wd_q) + 4'd1 + 4'(cur_leap);
  assign wd_y_next = (wd_y_sum >= 4'd7) ? WDW'(wd_y_sum - 4'd7) : WDW'(wd_y_sum);
  assign wd_m_sum  = 4'(wd_q) + 4'(dim - 5'd28);
  assign wd_m_next = (wd_m_sum >= 4'd7) ? WDW'(wd_m_sum - 4'd7) : WDW'(wd_m_sum);

  assign year_full = (YOW+YW)'(BASE_YEAR) + (YOW+YW)'(yoff_q);
  assign wd_final  = mod7_small(6'(wd_q) + 6'(dn_q[DW-1:0]) - 6'd1);

  assign status_o.date_ok    = date_ok_q;
  assign status_o.in_range   = range_ok_q;
  assign status_o.year_more  = (dn_q > ylen);
  assign status_o.month_more = (mon_q < 4'd12) && (dn_q > signed'(DNW'(dim)));

  always_ff @(posedge clk_i) begin
    case (op_i)
      DP_LOAD: begin
        year_q   <= in_year_i;
        month_q  <= in_month_i;
        day_q    <= in_day_i;
        offset_q <= offset_days_i;
      end
      DP_QYEAR: begin
        qy_q <= quot;
      end
      DP_QSHIFT: begin
        qs_q   <= quot;
        leap_q <= leap_in;
      end
      DP_BASE: begin
        dby_q     <= dby_d;
        date_ok_q <= date_ok_d;
      end
      DP_SUM: begin
        dn_q <= dn_sum;
      end
      DP_RANGE: begin
        range_ok_q <= (dn_q >= ONE_S) && (dn_q <= LAST_DAY_S);
        dnum_q     <= dn_q[DNOW-1:0];
        yoff_q     <= '0;
        c4_q       <= 2'd0;
        c100_q     <= 7'd0;
        c400_q     <= 9'd300;
        mon_q      <= 4'd1;
        wd_q       <= '0;
      end
      DP_YEAR: begin
        dn_q   <= dn_q - ylen;
        yoff_q <= yoff_q + YOW'(1);
        c4_q   <= c4_q + 2'd1;
        c100_q <= (c100_q == 7'd99) ? 7'd0 : c100_q + 7'd1;
        c400_q <= (c400_q == 9'd399) ? 9'd0 : c400_q + 9'd1;
        wd_q   <= wd_y_next;
      end
      DP_MONTH: begin
        dn_q  <= dn_q - signed'(DNW'(dim));
        mon_q <= mon_q + 4'd1;
        wd_q  <= wd_m_next;
      end
      DP_OUT: begin
        date_valid_o   <= date_ok_q;
        out_of_range_o <= date_ok_q && !range_ok_q;
        if (date_ok_q && range_ok_q) begin
          out_year_o   <= year_full[YW-1:0];
          out_month_o  <= mon_q;
          out_day_o    <= dn_q[DW-1:0];
          weekday_o    <= wd_final;
          day_number_o <= dnum_q;
        end else begin
          out_year_o   <= '0;
          out_month_o  <= '0;
          out_day_o    <= '0;
          weekday_o    <= '0;
          day_number_o <= '0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ test/calendar_date_offset_unit_top_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for calendar_date_offset_unit_top: directed and random date shifts,
// checked against typed results or an in-bench calendar predictor. Depends on cdo_pkg and the RTL top.
module calendar_date_offset_unit_top_tb;
  import cdo_pkg::*;

  localparam int N_RANDOM = 1780;
  localparam int N_DIRECTED = 24;
  localparam int SETTLE_CYCLES = 300;
  localparam int MAX_REPORTS = 10;
  localparam int MONTH_DAYS [13] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef struct {
    logic [YW-1:0]        year;
    logic [MW-1:0]        month;
    logic [DW-1:0]        day;
    logic signed [OW-1:0] offset;
  } date_req_t;

  typedef struct {
    logic             valid;
    logic             oor;
    logic [YW-1:0]    year;
    logic [MW-1:0]    month;
    logic [DW-1:0]    day;
    logic [WDW-1:0]   wday;
    logic [DNOW-1:0]  dnum;
  } date_result_t;

  typedef struct {
    date_req_t    req;
    bit           typed;
    date_result_t want;
  } date_case_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [YW-1:0]        in_year_i;
  logic [MW-1:0]        in_month_i;
  logic [DW-1:0]        in_day_i;
  logic signed [OW-1:0] offset_days_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic                 date_valid_o;
  logic                 out_of_range_o;
  logic [YW-1:0]        out_year_o;
  logic [MW-1:0]        out_month_o;
  logic [DW-1:0]        out_day_o;
  logic [WDW-1:0]       weekday_o;
  logic [DNOW-1:0]      day_number_o;

  date_result_t pending_dates [$];
  int burst_left = 0;
  int accepted_count = 0;
  int shifted_count = 0;
  int out_of_span_count = 0;
  int rejected_count = 0;
  int mismatch_count = 0;

  calendar_date_offset_unit_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_year_i      (in_year_i),
    .in_month_i     (in_month_i),
    .in_day_i       (in_day_i),
    .offset_days_i  (offset_days_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .date_valid_o   (date_valid_o),
    .out_of_range_o (out_of_range_o),
    .out_year_o     (out_year_o),
    .out_month_o    (out_month_o),
    .out_day_o      (out_day_o),
    .weekday_o      (weekday_o),
    .day_number_o   (day_number_o)
  );

  function automatic bit is_leap(longint y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic longint month_days(longint y, int m);
    if (m < 1 || m > 12) begin
      return 0;
    end
    return MONTH_DAYS[m] + ((m == 2 && is_leap(y)) ? 1 : 0);
  endfunction

  // leap years up to n, in a frame shifted by 400 years; only differences matter
  function automatic longint leaps_through(longint n);
    longint s;
    s = n + 400;
    return s / 4 - s / 100 + s / 400;
  endfunction

  // day number of Dec 31 of the previous year
  function automatic longint year_start(longint y);
    return 365 * (y - BASE_YEAR) + leaps_through(y - 1) - leaps_through(BASE_YEAR - 1);
  endfunction

  function automatic date_result_t shift_date(logic [YW-1:0] yr, logic [MW-1:0] mo,
                                              logic [DW-1:0] dy, logic signed [OW-1:0] off);
    date_result_t r;
    longint dn;
    longint y;
    int m;
    r = '{default: '0};
    if (mo < 1 || mo > 12 || dy < 1 || dy > month_days(yr, mo)) begin
      return r;
    end
    r.valid = 1'b1;
    dn = year_start(yr);
    for (m = 1; m < mo; m++) begin
      dn += month_days(yr, m);
    end
    dn += dy;
    dn -= longint'(off);
    if (dn < 1 || dn > year_start(BASE_YEAR + YEAR_SPAN)) begin
      r.oor = 1'b1;
      return r;
    end
    r.dnum = dn[DNOW-1:0];
    r.wday = WDW'((dn - 1) % 7);
    y = BASE_YEAR;
    while (dn > 365 + (is_leap(y) ? 1 : 0)) begin
      dn -= 365 + (is_leap(y) ? 1 : 0);
      y++;
    end
    m = 1;
    while (m < 12 && dn > month_days(y, m)) begin
      dn -= month_days(y, m);
      m++;
    end
    r.year = y[YW-1:0];
    r.month = MW'(m);
    r.day = dn[DW-1:0];
    return r;
  endfunction

  function automatic string fmt_result(date_result_t r);
    return $sformatf("valid=%0b oor=%0b date=%0d-%0d-%0d wd=%0d dn=%0d",
                     r.valid, r.oor, r.year, r.month, r.day, r.wday, r.dnum);
  endfunction

  function automatic date_req_t pick_date();
    date_req_t rq;
    date_result_t start;
    int kind;
    longint target;
    longint off;
    kind = $urandom_range(0, 99);
    rq.year = YW'($urandom_range(BASE_YEAR, BASE_YEAR + YEAR_SPAN - 1));
    if (kind < 10) begin
      rq.year = YW'($urandom);
    end else if (kind < 20) begin
      rq.year = YW'($urandom_range(1811, 2244));
    end else if (kind < 30) begin
      rq.year = ($urandom_range(0, 1) == 0) ? YW'($urandom_range(1900, 1905))
                                            : YW'($urandom_range(2150, 2155));
    end
    rq.month = MW'($urandom_range(1, 12));
    rq.day = DW'($urandom_range(1, int'(month_days(rq.year, rq.month))));
    case ($urandom_range(0, 3))
      0: begin
        rq.offset = OW'(int'($urandom_range(0, 800)) - 400);
      end
      1: begin
        rq.offset = OW'(int'($urandom_range(0, 16000)) - 8000);
      end
      2: begin
        rq.offset = OW'($urandom);
      end
      default: begin
        // land on or next to either end of the span
        start = shift_date(rq.year, rq.month, rq.day, '0);
        target = ($urandom_range(0, 1) == 0) ? 1 : year_start(BASE_YEAR + YEAR_SPAN);
        off = longint'(start.dnum) - target + int'($urandom_range(0, 2)) - 1;
        rq.offset = (off >= -32768 && off <= 32767) ? OW'(off) : OW'($urandom);
      end
    endcase
    if (kind >= 90) begin
      rq.year = YW'($urandom);
      rq.month = MW'($urandom);
      rq.day = DW'($urandom);
      rq.offset = OW'($urandom);
    end
    return rq;
  endfunction

  task automatic send_date(input date_req_t rq, input date_result_t want);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = 0;
      if ($urandom_range(0, 2) != 0) begin
        gap = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 320) : $urandom_range(1, 12);
      end
      repeat (gap) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_year_i <= rq.year;
    in_month_i <= rq.month;
    in_day_i <= rq.day;
    offset_days_i <= rq.offset;
    do @(posedge clk_i); while (in_stall_o);
    pending_dates.push_back(want);
    accepted_count++;
  endtask

  task automatic drain_results();
    do begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end while (pending_dates.size() != 0);
  endtask

  date_case_t directed_cases [N_DIRECTED] = '{
    '{'{12'd1900, 4'd1, 5'd1, 16'sd0}, 1'b1, '{1'b1, 1'b0, 12'd1900, 4'd1, 5'd1, 3'd0, 17'd1}},
    '{'{12'd1900, 4'd1, 5'd1, 16'sd1}, 1'b1, '{1'b1, 1'b1, 12'd0, 4'd0, 5'd0, 3'd0, 17'd0}},
    '{'{12'd2155, 4'd12, 5'd31, 16'sd0}, 1'b1,
      '{1'b1, 1'b0, 12'd2155, 4'd12, 5'd31, 3'd2, 17'd93502}},
    '{'{12'd2155, 4'd12, 5'd31, -16'sd1}, 1'b1, '{1'b1, 1'b1, 12'd0, 4'd0, 5'd0, 3'd0, 17'd0}},
    '{'{12'd2000, 4'd0, 5'd15, 16'sd0}, 1'b1, '{1'b0, 1'b0, 12'd0, 4'd0, 5'd0, 3'd0, 17'd0}},
    '{'{12'd2000, 4'd13, 5'd1, 16'sd0}, 1'b1, '{1'b0, 1'b0, 12'd0, 4'd0, 5'd0, 3'd0, 17'd0}},
    '{'{12'd4095, 4'd15, 5'd31, 16'sd32767}, 1'b1,
      '{1'b0, 1'b0, 12'd0, 4'd0, 5'd0, 3'd0, 17'd0}},
    '{'{12'd1999, 4'd6, 5'd0, 16'sd0}, 1'b1, '{1'b0, 1'b0, 12'd0, 4'd0, 5'd0, 3'd0, 17'd0}},
    '{'{12'd1900, 4'd2, 5'd29, 16'sd0}, 1'b1, '{1'b0, 1'b0, 12'd0, 4'd0, 5'd0, 3'd0, 17'd0}},
    '{'{12'd2001, 4'd4, 5'd31, 16'sd0}, 1'b1, '{1'b0, 1'b0, 12'd0, 4'd0, 5'd0, 3'd0, 17'd0}},
    '{'{12'd2002, 4'd9, 5'd31, 16'sd0}, 1'b1, '{1'b0, 1'b0, 12'd0, 4'd0, 5'd0, 3'd0, 17'd0}},
    '{'{12'd2003, 4'd6, 5'd31, 16'sd0}, 1'b1, '{1'b0, 1'b0, 12'd0, 4'd0, 5'd0, 3'd0, 17'd0}},
    '{'{12'd2000, 4'd2, 5'd30, 16'sd0}, 1'b1, '{1'b0, 1'b0, 12'd0, 4'd0, 5'd0, 3'd0, 17'd0}},
    '{'{12'd0, 4'd1, 5'd1, 16'sd0}, 1'b1, '{1'b1, 1'b1, 12'd0, 4'd0, 5'd0, 3'd0, 17'd0}},
    '{'{12'd4095, 4'd12, 5'd31, 16'sd32767}, 1'b1,
      '{1'b1, 1'b1, 12'd0, 4'd0, 5'd0, 3'd0, 17'd0}},
    '{'{12'd2000, 4'd2, 5'd29, 16'sd0}, 1'b0, '{default: '0}},
    '{'{12'd1900, 4'd1, 5'd1, 16'sh8000}, 1'b0, '{default: '0}},
    '{'{12'd2155, 4'd12, 5'd31, 16'sd32767}, 1'b0, '{default: '0}},
    '{'{12'd1900, 4'd2, 5'd28, -16'sd1}, 1'b0, '{default: '0}},
    '{'{12'd2100, 4'd12, 5'd31, 16'sd0}, 1'b0, '{default: '0}},
    '{'{12'd1812, 4'd6, 5'd15, -16'sd32000}, 1'b0, '{default: '0}},
    '{'{12'd2240, 4'd1, 5'd1, 16'sd32767}, 1'b0, '{default: '0}},
    '{'{12'd2024, 4'd2, 5'd29, 16'sd365}, 1'b0, '{default: '0}},
    '{'{12'd2155, 4'd1, 5'd1, -16'sd364}, 1'b0, '{default: '0}}
  };

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver stall: stretches at a random stall density, zero included
  initial begin
    int pct;
    out_stall_i = 1'b0;
    forever begin
      case ($urandom_range(0, 3))
        0: pct = 0;
        1: pct = 25;
        2: pct = 50;
        default: pct = 90;
      endcase
      repeat ($urandom_range(20, 400)) begin
        @(negedge clk_i);
        out_stall_i <= ($urandom_range(0, 99) < pct);
      end
    end
  end

  initial begin
    date_result_t want;
    date_result_t got;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        got = '{date_valid_o, out_of_range_o, out_year_o, out_month_o, out_day_o,
                weekday_o, day_number_o};
        if (pending_dates.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: unexpected result %s", $time, fmt_result(got));
          end
        end else begin
          want = pending_dates.pop_front();
          if (got.valid !== want.valid || got.oor !== want.oor || got.year !== want.year ||
              got.month !== want.month || got.day !== want.day || got.wday !== want.wday ||
              got.dnum !== want.dnum) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
              $display("%0t: mismatch, expected %s", $time, fmt_result(want));
              $display("%0t:           got      %s", $time, fmt_result(got));
            end
          end
          if (!want.valid) begin
            rejected_count++;
          end else if (want.oor) begin
            out_of_span_count++;
          end else begin
            shifted_count++;
          end
        end
      end
    end
  end

  initial begin
    #(100_000_000);
    $display("timeout with %0d results outstanding", pending_dates.size());
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    date_req_t rq;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_year_i = '0;
    in_month_i = '0;
    in_day_i = '0;
    offset_days_i = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_cases[i]) begin
      rq = directed_cases[i].req;
      send_date(rq, directed_cases[i].typed ? directed_cases[i].want
                                            : shift_date(rq.year, rq.month, rq.day, rq.offset));
    end
    drain_results();

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 2) begin
        drain_results();
      end
      rq = pick_date();
      send_date(rq, shift_date(rq.year, rq.month, rq.day, rq.offset));
    end
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("%0d transactions (%0d directed): %0d dates moved in span, %0d moved out of span,",
             accepted_count, N_DIRECTED, shifted_count, out_of_span_count);
    $display("%0d illegal dates rejected, %0d mismatches", rejected_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
